@@ hdl/ilts_pkg.sv @@
// ----------------------------------------------------------------------------
// Illuminated line texel shader package
// Shared types, constants and elaboration-time table functions.
// ----------------------------------------------------------------------------
package ilts_pkg;

   localparam int TEX_W     = 8;
   localparam int TAB_DEPTH = 2 ** TEX_W;
   localparam int Q_ONE     = 65536;
   localparam int Q_W       = 17;
   localparam int NL_W      = 21;
   localparam int P_W       = 27;
   localparam int EXP_W     = 15;
   localparam int COEF_W    = 16;
   localparam int OUT_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int ACC_W     = 31;
   localparam int FRAC_W    = 16;

   localparam logic [OUT_W-1:0] NINE_TENTHS = 16'd58982;

   typedef logic [Q_W-1:0] q16_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DIFF_EXP = 3'd0,
      REG_SPEC_EXP = 3'd1,
      REG_AMBIENT  = 3'd2,
      REG_DIFFUSE  = 3'd3,
      REG_SPECULAR = 3'd4,
      REG_LIGHT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      q16_type          lt;
      logic             neg_l;
      q16_type          sl;
      logic [NL_W-1:0]  nl_x;
      q16_type          vt;
      logic             neg_v;
      q16_type          sv;
   } coord_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'h1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic q16_type sin_q16(input int t);
      logic [63:0] sq;
      logic [63:0] om;
      sq = (64'(t) * 64'(t) + 64'd32768) >> 16;
      om = (sq >= 64'(Q_ONE)) ? 64'd0 : 64'(Q_ONE) - sq;
      return Q_W'(isqrt64(om << 16));
   endfunction

   function automatic logic [NL_W-1:0] log2_neg(input q16_type x);
      logic [63:0]       m;
      logic [FRAC_W-1:0] frac;
      int                k;
      k = 0;
      frac = '0;
      if (x == '0 || x >= Q_W'(Q_ONE)) begin
         return '0;
      end
      for (int i = 0; i < 16; i++) begin
         if (x[i]) begin
            k = i;
         end
      end
      m = 64'(x) << (30 - k);
      for (int i = 1; i <= 16; i++) begin
         m = (m * m) >> 30;
         frac = {frac[FRAC_W-2:0], 1'b0};
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return NL_W'((16 - k) * Q_ONE - int'(frac));
   endfunction

   function automatic logic [29:0] exp_factor(input int i);
      logic [63:0] c;
      c = isqrt64(64'h1 << 59);
      for (int j = 2; j <= 16; j++) begin
         if (j <= i) begin
            c = isqrt64(c << 30);
         end
      end
      return c[29:0];
   endfunction

endpackage

@@ hdl/ilts_coord.sv @@
// ----------------------------------------------------------------------------
// Texel coordinate mapper
// Looks up tangent magnitudes, signs, sines and the diffuse log per texel.
// ----------------------------------------------------------------------------
module ilts_coord
   import ilts_pkg::*;
#(
   parameter int TEX_SIZE = 256
) (
   input  logic             clock,
   input  logic             en,
   input  logic [TEX_W-1:0] tex_x,
   input  logic [TEX_W-1:0] tex_y,
   output coord_type        coord
);

   localparam int N = TEX_SIZE - 1;

   q16_type          mag_tab [TAB_DEPTH];
   logic             neg_tab [TAB_DEPTH];
   q16_type          sin_tab [TAB_DEPTH];
   logic [NL_W-1:0]  log_tab [TAB_DEPTH];
   coord_type        coord_ff;

   for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
      localparam int C   = (g > N) ? N : g;
      localparam int A   = (2 * C < N) ? (N - 2 * C) : (2 * C - N);
      localparam int MAG = (A * Q_ONE + N / 2) / N;
      assign mag_tab[g] = Q_W'(MAG);
      assign neg_tab[g] = (2 * C < N);
      assign sin_tab[g] = sin_q16(MAG);
      assign log_tab[g] = log2_neg(sin_q16(MAG));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         coord_ff.lt    <= mag_tab[tex_x];
         coord_ff.neg_l <= neg_tab[tex_x];
         coord_ff.sl    <= sin_tab[tex_x];
         coord_ff.nl_x  <= log_tab[tex_x];
         coord_ff.vt    <= mag_tab[tex_y];
         coord_ff.neg_v <= neg_tab[tex_y];
         coord_ff.sv    <= sin_tab[tex_y];
      end
   end

   assign coord = coord_ff;

endmodule

@@ hdl/ilts_log2.sv @@
// ----------------------------------------------------------------------------
// Pipelined negative log2
// Normalizes a Q16 value and forms 16 fraction bits by repeated squaring.
// ----------------------------------------------------------------------------
module ilts_log2
   import ilts_pkg::*;
(
   input  logic            clock,
   input  logic            en,
   input  q16_type         x,
   output logic [NL_W-1:0] nl,
   output logic            is_zero,
   output logic            is_one
);

   logic [ACC_W-1:0]  m_ff    [17];
   logic [FRAC_W-1:0] frac_ff [17];
   logic [3:0]        k_ff    [17];
   logic              zero_ff [17];
   logic              one_ff  [17];
   logic [NL_W-1:0]   nl_ff;
   logic              zero_out_ff;
   logic              one_out_ff;
   logic [3:0]        k_in;

   always_comb begin
      k_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (x[i]) begin
            k_in = 4'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]    <= ACC_W'(x[15:0]) << (5'd30 - 5'(k_in));
         frac_ff[0] <= '0;
         k_ff[0]    <= k_in;
         zero_ff[0] <= (x == '0);
         one_ff[0]  <= (x >= Q_W'(Q_ONE));
      end
   end

   for (genvar s = 1; s <= 16; s++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] m2;
      assign sq = 62'(m_ff[s-1]) * 62'(m_ff[s-1]);
      assign m2 = sq[61:30];
      always_ff @(posedge clock) begin
         if (en) begin
            if (m2[31]) begin
               m_ff[s]    <= m2[31:1];
               frac_ff[s] <= {frac_ff[s-1][FRAC_W-2:0], 1'b1};
            end else begin
               m_ff[s]    <= m2[30:0];
               frac_ff[s] <= {frac_ff[s-1][FRAC_W-2:0], 1'b0};
            end
            k_ff[s]    <= k_ff[s-1];
            zero_ff[s] <= zero_ff[s-1];
            one_ff[s]  <= one_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nl_ff       <= {5'd16 - 5'(k_ff[16]), 16'b0} - NL_W'(frac_ff[16]);
         zero_out_ff <= zero_ff[16];
         one_out_ff  <= one_ff[16];
      end
   end

   assign nl      = nl_ff;
   assign is_zero = zero_out_ff;
   assign is_one  = one_out_ff;

endmodule

@@ hdl/ilts_exp2.sv @@
// ----------------------------------------------------------------------------
// Pipelined negative exp2
// Multiplies in one constant root of two per fraction bit, then shifts.
// ----------------------------------------------------------------------------
module ilts_exp2
   import ilts_pkg::*;
(
   input  logic           clock,
   input  logic           en,
   input  logic [P_W-1:0] p,
   input  logic           force_en,
   input  logic           force_one,
   output q16_type        value
);

   localparam int IP_W = P_W - 16;

   logic [ACC_W-1:0] acc_ff  [17];
   logic [15:0]      f_ff    [17];
   logic [IP_W-1:0]  ip_ff   [17];
   logic             fen_ff  [17];
   logic             fone_ff [17];
   q16_type          value_ff;
   q16_type          base;

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff[0]  <= ACC_W'(1) << 30;
         f_ff[0]    <= p[15:0];
         ip_ff[0]   <= p[P_W-1:16];
         fen_ff[0]  <= force_en;
         fone_ff[0] <= force_one;
      end
   end

   for (genvar s = 1; s <= 16; s++) begin : g_mul
      localparam logic [29:0] C = exp_factor(s);
      logic [60:0] prod;
      assign prod = 61'(acc_ff[s-1]) * 61'(C);
      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[s]  <= f_ff[s-1][16-s] ? ACC_W'(prod >> 30) : acc_ff[s-1];
            f_ff[s]    <= f_ff[s-1];
            ip_ff[s]   <= ip_ff[s-1];
            fen_ff[s]  <= fen_ff[s-1];
            fone_ff[s] <= fone_ff[s-1];
         end
      end
   end

   assign base = Q_W'(acc_ff[16] >> 14);

   always_ff @(posedge clock) begin
      if (en) begin
         if (fen_ff[16]) begin
            value_ff <= fone_ff[16] ? Q_W'(Q_ONE) : '0;
         end else if (ip_ff[16] > IP_W'(16)) begin
            value_ff <= '0;
         end else begin
            value_ff <= base >> ip_ff[16];
         end
      end
   end

   assign value = value_ff;

endmodule

@@ hdl/illuminated_line_texel_shader_unit.sv @@
// ----------------------------------------------------------------------------
// Illuminated line texel shader
// Computes diffuse and specular lighting values for one texel per cycle while req_tready is high.
// ----------------------------------------------------------------------------
// The req channel carries one texel coordinate pair per transfer. The rsp
// channel returns the diffuse and specular values of that texel, in order.
// The csr port writes the exponents and the material and light coefficients;
// the user must write it only while no texel is in flight; the block does not enforce this.
// One texel is accepted every cycle while req_tready is high. A result passes
// through 44 pipeline stages (table lookup, products, a 16-stage squaring log,
// a 16-stage multiplying exp and the output arithmetic) and then the two-entry
// output buffer before it can be taken.
// The output buffer holds two results. When rsp_tready is low and the buffer
// fills, req_tready drops and the whole pipeline holds its contents.
// Reset empties the pipeline and the buffer and loads the register defaults.
// ----------------------------------------------------------------------------
module illuminated_line_texel_shader_unit
   import ilts_pkg::*;
#(
   parameter int TEX_SIZE = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // tex_x, tex_y
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata,   // diffuse_value, specular_value
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   localparam int LAT     = 44;
   localparam int DLY_LEN = 20;

   logic [EXP_W-1:0]  diff_exp_ff;
   logic [EXP_W-1:0]  spec_exp_ff;
   logic [COEF_W-1:0] ambient_ff;
   logic [COEF_W-1:0] diffuse_ff;
   logic [COEF_W-1:0] specular_ff;
   logic [COEF_W-1:0] light_ff;
   logic [31:0]       al_ff;

   logic              pipe_en;
   logic              valid_ff [LAT];
   coord_type         coord;

   q16_type           p1_ff;
   q16_type           p2_ff;
   logic              sgn_ff;
   logic [P_W-1:0]    pd_ff;
   logic              dfe_ff;
   logic              dfo_ff;
   logic [P_W-1:0]    pd_dly_ff  [DLY_LEN];
   logic              dfe_dly_ff [DLY_LEN];
   logic              dfo_dly_ff [DLY_LEN];

   logic signed [18:0] dot;
   q16_type           mag_in;
   q16_type           mag_ff;

   logic [NL_W-1:0]   nl_s;
   logic              s_zero;
   logic              s_one;
   logic [P_W-1:0]    ps_ff;
   logic              sfe_ff;
   logic              sfo_ff;

   q16_type           dterm;
   q16_type           sterm;
   logic [32:0]       t1_ff;
   logic [32:0]       s1_ff;
   logic [48:0]       dp_ff;
   logic [48:0]       sp_ff;
   logic [49:0]       dsum;
   logic [18:0]       dq;
   logic [17:0]       sq;
   logic [OUT_W-1:0]  d_ff;
   logic [OUT_W-1:0]  s_ff;
   logic [OUT_W-1:0]  dout_ff;
   logic [OUT_W-1:0]  sout_ff;
   logic [32:0]       s_scaled;

   logic [31:0]       fifo_data_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        cnt_ff;
   logic              push;
   logic              pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_exp_ff <= 15'd256;
         spec_exp_ff <= 15'd8192;
         ambient_ff  <= 16'd0;
         diffuse_ff  <= 16'd32768;
         specular_ff <= 16'd32768;
         light_ff    <= 16'd32768;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_DIFF_EXP: begin
               diff_exp_ff <= csr_wdata[EXP_W-1:0];
            end
            REG_SPEC_EXP: begin
               spec_exp_ff <= csr_wdata[EXP_W-1:0];
            end
            REG_AMBIENT: begin
               ambient_ff <= csr_wdata;
            end
            REG_DIFFUSE: begin
               diffuse_ff <= csr_wdata;
            end
            REG_SPECULAR: begin
               specular_ff <= csr_wdata;
            end
            REG_LIGHT: begin
               light_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      al_ff <= 32'(ambient_ff) * 32'(light_ff);
   end

   assign pipe_en    = (cnt_ff != 2'd2);
   assign req_tready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (pipe_en) begin
         valid_ff[0] <= req_tvalid;
         for (int i = 1; i < LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   ilts_coord #(
      .TEX_SIZE(TEX_SIZE)
   ) u_coord (
      .clock(clock),
      .en   (pipe_en),
      .tex_x(req_tdata[7:0]),
      .tex_y(req_tdata[15:8]),
      .coord(coord)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         p1_ff  <= Q_W'((34'(coord.lt) * 34'(coord.vt) + 34'd32768) >> 16);
         p2_ff  <= Q_W'((34'(coord.sl) * 34'(coord.sv) + 34'd32768) >> 16);
         sgn_ff <= coord.neg_l ^ coord.neg_v;
         pd_ff  <= P_W'((36'(diff_exp_ff) * 36'(coord.nl_x)) >> 8);
         dfe_ff <= (diff_exp_ff == '0) || (coord.sl == '0) || (coord.sl >= Q_W'(Q_ONE));
         dfo_ff <= (diff_exp_ff == '0) || (coord.sl != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pd_dly_ff[0]  <= pd_ff;
         dfe_dly_ff[0] <= dfe_ff;
         dfo_dly_ff[0] <= dfo_ff;
         for (int i = 1; i < DLY_LEN; i++) begin
            pd_dly_ff[i]  <= pd_dly_ff[i-1];
            dfe_dly_ff[i] <= dfe_dly_ff[i-1];
            dfo_dly_ff[i] <= dfo_dly_ff[i-1];
         end
      end
   end

   always_comb begin
      dot = (sgn_ff ? -$signed({2'b00, p1_ff}) : $signed({2'b00, p1_ff}))
            - $signed({2'b00, p2_ff});
      if (dot < -19'sd65536 || dot > 19'sd65536) begin
         mag_in = Q_W'(Q_ONE);
      end else if (dot < 19'sd0) begin
         mag_in = Q_W'(-dot);
      end else begin
         mag_in = Q_W'(dot);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mag_ff <= mag_in;
      end
   end

   ilts_log2 u_log2 (
      .clock  (clock),
      .en     (pipe_en),
      .x      (mag_ff),
      .nl     (nl_s),
      .is_zero(s_zero),
      .is_one (s_one)
   );

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ps_ff  <= P_W'((36'(spec_exp_ff) * 36'(nl_s)) >> 8);
         sfe_ff <= (spec_exp_ff == '0) || s_zero || s_one;
         sfo_ff <= (spec_exp_ff == '0) || !s_zero;
      end
   end

   ilts_exp2 u_exp_diffuse (
      .clock    (clock),
      .en       (pipe_en),
      .p        (pd_dly_ff[DLY_LEN-1]),
      .force_en (dfe_dly_ff[DLY_LEN-1]),
      .force_one(dfo_dly_ff[DLY_LEN-1]),
      .value    (dterm)
   );

   ilts_exp2 u_exp_specular (
      .clock    (clock),
      .en       (pipe_en),
      .p        (ps_ff),
      .force_en (sfe_ff),
      .force_one(sfo_ff),
      .value    (sterm)
   );

   assign dsum     = 50'({al_ff, 16'b0}) + 50'(dp_ff);
   assign dq       = 19'(dsum >> 31);
   assign sq       = 18'(sp_ff >> 31);
   assign s_scaled = (33'(s_ff) * 33'(NINE_TENTHS) + 33'd32768) >> 16;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         t1_ff   <= 33'(dterm) * 33'(diffuse_ff);
         s1_ff   <= 33'(sterm) * 33'(specular_ff);
         dp_ff   <= 49'(t1_ff) * 49'(light_ff);
         sp_ff   <= 49'(s1_ff) * 49'(light_ff);
         d_ff    <= (dq > 19'd65535) ? 16'hFFFF : dq[15:0];
         s_ff    <= (sq > 18'd65535) ? 16'hFFFF : sq[15:0];
         dout_ff <= d_ff;
         sout_ff <= s_scaled[15:0];
      end
   end

   assign push = pipe_en && valid_ff[LAT-1];
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_data_ff[wr_ptr_ff] <= {sout_ff, dout_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = fifo_data_ff[rd_ptr_ff];

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> cnt_ff == 2'($past(cnt_ff) + 2'($past(push)) - 2'($past(pop))))
      else $error("output buffer count does not follow push and pop");

   a_spec_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:16] <= NINE_TENTHS)
      else $error("specular value above its scaled maximum");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Illuminated line texel shader testbench
// Drives texel coordinates through the shader, predicts the diffuse and
// specular values in fixed point and compares every result transfer in order.
// ----------------------------------------------------------------------------
module tb;
   import ilts_pkg::*;

   localparam int TEX_N = 256;
   localparam int WDOG_LIMIT = 20000;
   localparam int LONG_HOLD = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COEF_W-1:0] csr_wdata = '0;

   illuminated_line_texel_shader_unit #(.TEX_SIZE(TEX_N)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   logic [63:0] diff_exp, spec_exp, amb_coef, diff_coef, spec_coef, light_int;
   logic [15:0] texel_queue[$];
   logic [31:0] shade_queue[$];
   logic [15:0] corner_texels [14] = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00,
                                       16'h7F7F, 16'h8080, 16'h7F80, 16'h807F,
                                       16'h0080, 16'h8000, 16'hFE01, 16'h01FE,
                                       16'h5555, 16'hAAAA};
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_recv = 0;
   int hold_req = 0;
   int hold_seen = 0;
   bit send_pause = 1'b0;
   int errors = 0;
   int quiet_cycles = 0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
      logic [63:0] v, r, b;
      v = v_in;
      r = '0;
      b = 64'h1 << 62;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] coord_mag(input logic [63:0] c, output bit neg);
      logic [63:0] n, a;
      n = TEX_N - 1;
      if (c > n) c = n;
      neg = (2 * c < n);
      a = neg ? n - 2 * c : 2 * c - n;
      return (a * 65536 + n / 2) / n;
   endfunction

   function automatic logic [63:0] cosine_comp(input logic [63:0] t);
      logic [63:0] sq, om;
      sq = (t * t + 32768) >> 16;
      om = (sq >= 65536) ? 0 : 65536 - sq;
      return int_sqrt(om << 16);
   endfunction

   function automatic logic [63:0] fixed_pow(input logic [63:0] x, input logic [63:0] e);
      logic [63:0] m, frac, nlog, p, ip, f, acc, c;
      int k;
      if (e == 0) return 65536;
      if (x == 0) return 0;
      if (x >= 65536) return 65536;
      k = 0;
      frac = 0;
      while ((x >> (k + 1)) != 0) k++;
      m = x << (30 - k);
      for (int i = 1; i <= 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'h1 << 31)) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      nlog = 64'(16 - k) * 65536 - frac;
      p = (e * nlog) >> 8;
      ip = p >> 16;
      f = p & 64'hFFFF;
      if (ip > 16) return 0;
      acc = 64'h1 << 30;
      c = 0;
      for (int i = 1; i <= 16; i++) begin
         c = (i == 1) ? int_sqrt(64'h1 << 59) : int_sqrt(c << 30);
         if ((f >> (16 - i)) & 1) acc = (acc * c) >> 30;
      end
      return (acc >> 14) >> ip;
   endfunction

   function automatic logic [31:0] shade_texel(input logic [15:0] texel);
      bit nl, nv;
      logic [63:0] lt, vt, sl, sv, dterm, p1, p2, mag, sterm, d, s;
      longint dot;
      lt = coord_mag(64'(texel[7:0]), nl);
      vt = coord_mag(64'(texel[15:8]), nv);
      sl = cosine_comp(lt);
      sv = cosine_comp(vt);
      dterm = fixed_pow(sl, diff_exp);
      p1 = (lt * vt + 32768) >> 16;
      p2 = (sl * sv + 32768) >> 16;
      dot = (nl != nv) ? -longint'(p1) - longint'(p2) : longint'(p1) - longint'(p2);
      if (dot < -65536) dot = -65536;
      if (dot > 65536) dot = 65536;
      mag = (dot < 0) ? 64'(-dot) : 64'(dot);
      sterm = fixed_pow(mag, spec_exp);
      d = (((amb_coef * light_int) << 16) + dterm * diff_coef * light_int) >> 31;
      if (d > 65535) d = 65535;
      s = (sterm * spec_coef * light_int) >> 31;
      if (s > 65535) s = 65535;
      s = (s * 58982 + 32768) >> 16;
      return {s[15:0], d[15:0]};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
      end else if (texel_queue.size() != 0 && !send_pause &&
                   $urandom_range(99) >= send_idle_pct) begin
         req_tvalid <= 1'b1;
         req_tdata <= texel_queue.pop_front();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_recv <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_recv > 0) begin
         hold_recv <= hold_recv - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            shade_queue.push_back(shade_texel(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (shade_queue.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               logic [31:0] want;
               want = shade_queue.pop_front();
               if (want[15:0] !== rsp_tdata[15:0] || want[31:16] !== rsp_tdata[31:16]) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("mismatch: diffuse exp %h got %h, specular exp %h got %h",
                              want[15:0], rsp_tdata[15:0], want[31:16], rsp_tdata[31:16]);
                  end
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || hold_recv > 0)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [63:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      case (idx)
         REG_DIFF_EXP: diff_exp = val & 64'h7FFF;
         REG_SPEC_EXP: spec_exp = val & 64'h7FFF;
         REG_AMBIENT:  amb_coef = val & 64'hFFFF;
         REG_DIFFUSE:  diff_coef = val & 64'hFFFF;
         REG_SPECULAR: spec_coef = val & 64'hFFFF;
         default:      light_int = val & 64'hFFFF;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      while (texel_queue.size() != 0 || req_tvalid || shade_queue.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_all(input logic [63:0] de, se, am, di, sp, li);
      write_reg(REG_DIFF_EXP, de);
      write_reg(REG_SPEC_EXP, se);
      write_reg(REG_AMBIENT, am);
      write_reg(REG_DIFFUSE, di);
      write_reg(REG_SPECULAR, sp);
      write_reg(REG_LIGHT, li);
   endtask

   task automatic push_random(input int count);
      for (int i = 0; i < count; i++)
         texel_queue.push_back(16'($urandom));
   endtask

   initial begin
      diff_exp = 256;
      spec_exp = 8192;
      amb_coef = 0;
      diff_coef = 32768;
      spec_coef = 32768;
      light_int = 32768;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed corners: table edges, center texels and the all-ones code.
      foreach (corner_texels[i])
         texel_queue.push_back(corner_texels[i]);
      drain();

      // Zero exponents and full-scale coefficients.
      set_all(0, 0, 65535, 65535, 65535, 65535);
      texel_queue.push_back(16'h0000);
      texel_queue.push_back(16'hFF00);
      texel_queue.push_back(16'h8080);
      push_random(6);
      drain();

      // Largest exponents.
      set_all(32767, 32767, 0, 65535, 65535, 65535);
      texel_queue.push_back(16'h7F7F);
      texel_queue.push_back(16'h0080);
      push_random(4);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         set_all($urandom_range(ph == 7 ? 32767 : 1024), $urandom_range(32767),
                 $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(65535), $urandom_range(65535));
         if (ph == 0) hold_req++;
         push_random(50);
         if (ph == 4) begin
            while (texel_queue.size() != 0 || req_tvalid) @(posedge clock);
            send_pause = 1'b1;
            while (shade_queue.size() != 0) @(posedge clock);
            send_pause = 1'b0;
         end
         push_random(50);
         drain();
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/ilts_pkg.sv
hdl/ilts_coord.sv
hdl/ilts_log2.sv
hdl/ilts_exp2.sv
hdl/illuminated_line_texel_shader_unit.sv
verif/tb.sv
